/* hw/rtl/lpc_pkg.sv */
package lpc_pkg;

  localparam int OFF_W  = 32;
  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 17;
  localparam int WIN_W  = 16;
  localparam int CNT_W  = 32;
  localparam int NUM_W  = 5;

  localparam logic [LEN_W-1:0] PAGE_MAX = 17'd65536;

  // request actions
  localparam logic [1:0] ACT_READ     = 2'd0;
  localparam logic [1:0] ACT_PREFETCH = 2'd1;
  localparam logic [1:0] ACT_FILL     = 2'd2;
  localparam logic [1:0] ACT_BAD      = 2'd3;

  // result status codes
  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_FILLED = 3'd2;
  localparam logic [2:0] ST_SHORT  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;
  localparam logic [2:0] ST_PREHIT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_PAGE_BYTES = 2'd0;
  localparam logic [1:0] REG_PAGES      = 2'd1;
  localparam logic [1:0] REG_FILE_LEN   = 2'd2;

  typedef struct packed {
    logic accept;
    logic div_go;
    logic div_latch;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic div_done;
    logic hit_now;
    logic scan_last;
  } sts_t;

endpackage

/* hw/rtl/lpc_div.sv */
module lpc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [lpc_pkg::OFF_W-1:0]  dividend,
  input  logic [lpc_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [lpc_pkg::WIN_W-1:0]  remainder
);

  logic                        run_r;
  logic [5:0]                  cnt_r;
  logic [lpc_pkg::OFF_W-1:0]   dvd_r;
  logic [lpc_pkg::LEN_W-1:0]   dsr_r;
  logic [lpc_pkg::LEN_W:0]     rem_r;
  logic [lpc_pkg::LEN_W:0]     shifted;
  logic [lpc_pkg::LEN_W:0]     rem_nxt;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r[lpc_pkg::LEN_W-1:0], dvd_r[lpc_pkg::OFF_W-1]};
    if (shifted >= {1'b0, dsr_r}) begin
      rem_nxt = shifted - {1'b0, dsr_r};
    end else begin
      rem_nxt = shifted;
    end
  end

  assign done      = run_r && (cnt_r == 6'(lpc_pkg::OFF_W));
  assign remainder = rem_r[lpc_pkg::WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (done) begin
      run_r <= 1'b0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r && !done) begin
      dvd_r <= {dvd_r[lpc_pkg::OFF_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule

/* hw/rtl/lpc_ctrl.sv */
module lpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lpc_pkg::sts_t sts,
  output lpc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIVIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (!sts.fast) begin
            cmd.div_go = 1'b1;
            state_nxt  = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit_now || sts.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/lpc_datapath.sv */
module lpc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpc_pkg::cmd_t               cmd,
  output lpc_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic [1:0]                  in_action,
  input  logic [lpc_pkg::OFF_W-1:0]   in_byte_offset,
  input  logic [lpc_pkg::LEN_W-1:0]   in_remaining_bytes,
  input  logic [lpc_pkg::LEN_W-1:0]   in_got_bytes,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [lpc_pkg::SLOT_W-1:0]  out_page_slot,
  output logic [lpc_pkg::OFF_W-1:0]   out_page_base,
  output logic [lpc_pkg::LEN_W-1:0]   out_fetch_length,
  output logic [lpc_pkg::WIN_W-1:0]   out_within_offset,
  output logic [lpc_pkg::LEN_W-1:0]   out_take_bytes,
  output logic [lpc_pkg::CNT_W-1:0]   out_hit_total,
  output logic [lpc_pkg::CNT_W-1:0]   out_miss_total,
  output logic [lpc_pkg::CNT_W-1:0]   out_short_read_total
);

  localparam int OW = lpc_pkg::OFF_W;
  localparam int LW = lpc_pkg::LEN_W;
  localparam int WW = lpc_pkg::WIN_W;
  localparam int SW = lpc_pkg::SLOT_W;
  localparam int CW = lpc_pkg::CNT_W;
  localparam int NW = lpc_pkg::NUM_W;

  function automatic logic [LW-1:0] take_from(input logic [LW-1:0] fill,
                                              input logic [WW-1:0] win,
                                              input logic [LW-1:0] want);
    logic [LW-1:0] avail;
    avail = fill - {1'b0, win};
    if ({1'b0, win} >= fill) begin
      return '0;
    end
    return (want < avail) ? want : avail;
  endfunction

  // configuration
  logic [LW-1:0] page_bytes_r;
  logic [NW-1:0] pages_r;
  logic [OW-1:0] flen_r;

  // slot table
  logic [lpc_pkg::SLOTS-1:0] valid_r;
  logic [OW-1:0]             tag_r   [lpc_pkg::SLOTS];
  logic [LW-1:0]             fill_r  [lpc_pkg::SLOTS];
  logic [CW-1:0]             stamp_r [lpc_pkg::SLOTS];

  logic [CW-1:0] stamp_cnt_r, hit_cnt_r, miss_cnt_r, short_cnt_r;

  // pending fetch
  logic          pend_r;
  logic [SW-1:0] pend_slot_r;
  logic [OW-1:0] pend_base_r;
  logic [LW-1:0] pend_len_r;
  logic          pend_read_r;
  logic [WW-1:0] pend_within_r;
  logic [LW-1:0] pend_rem_r;

  // request in flight
  logic          is_read_r;
  logic [OW-1:0] off_r;
  logic [LW-1:0] rem_r;
  logic [OW-1:0] base_r;
  logic [WW-1:0] within_r;

  // scan state
  logic [SW-1:0] idx_r, vict_r, hslot_r;
  logic          free_r, hit_r;
  logic [CW-1:0] vstamp_r;

  // results
  logic          ov_r;
  logic [2:0]    ost_r;
  logic [SW-1:0] oslot_r;
  logic [OW-1:0] obase_r;
  logic [LW-1:0] oflen_r;
  logic [WW-1:0] owin_r;
  logic [LW-1:0] otake_r;

  logic [LW-1:0] pb;
  logic [NW-1:0] n_act;
  logic          reject;
  logic [OW-1:0] avail_in;
  logic [LW-1:0] rem_clamp;
  logic          div_done;
  logic [WW-1:0] div_rem;
  logic [OW-1:0] avail_base;
  logic [LW-1:0] want;
  logic [CW-1:0] stamp_inc;

  assign pb    = (page_bytes_r > lpc_pkg::PAGE_MAX) ? lpc_pkg::PAGE_MAX : page_bytes_r;
  assign n_act = (pages_r == '0) ? NW'(1) :
                 (pages_r > NW'(lpc_pkg::SLOTS)) ? NW'(lpc_pkg::SLOTS) : pages_r;

  // decide at accept whether the request needs the divider
  always_comb begin
    if (in_action == lpc_pkg::ACT_BAD) begin
      reject = 1'b1;
    end else if (in_action == lpc_pkg::ACT_FILL) begin
      reject = !pend_r;
    end else begin
      reject = pend_r || (flen_r == '0) || (in_byte_offset >= flen_r) || (pb == '0) ||
               ((in_action == lpc_pkg::ACT_READ) && (in_remaining_bytes == '0));
    end
  end

  assign avail_in  = flen_r - in_byte_offset;
  assign rem_clamp = ({{(OW-LW){1'b0}}, in_remaining_bytes} > avail_in) ?
                     avail_in[LW-1:0] : in_remaining_bytes;

  assign avail_base = flen_r - base_r;
  assign want       = ({{(OW-LW){1'b0}}, pb} > avail_base) ? avail_base[LW-1:0] : pb;
  assign stamp_inc  = stamp_cnt_r + CW'(1);

  assign sts.fast      = reject || (in_action == lpc_pkg::ACT_FILL);
  assign sts.div_done  = div_done;
  assign sts.hit_now   = valid_r[idx_r] && (tag_r[idx_r] == base_r);
  assign sts.scan_last = ({1'b0, idx_r} == (n_act - NW'(1)));

  lpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.div_go),
    .dividend  (in_byte_offset),
    .divisor   (pb),
    .done      (div_done),
    .remainder (div_rem)
  );

  // control, counters and slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r <= LW'(512);
      pages_r      <= NW'(lpc_pkg::SLOTS);
      flen_r       <= '0;
      valid_r      <= '0;
      for (int i = 0; i < lpc_pkg::SLOTS; i++) begin
        tag_r[i]   <= '0;
        fill_r[i]  <= '0;
        stamp_r[i] <= '0;
      end
      stamp_cnt_r <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      short_cnt_r <= '0;
      pend_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      ov_r <= (cmd.accept && sts.fast) || cmd.finish;
      if (cfg_we) begin
        case (cfg_index)
          lpc_pkg::REG_PAGE_BYTES: page_bytes_r <= cfg_data[LW-1:0];
          lpc_pkg::REG_PAGES:      pages_r      <= cfg_data[NW-1:0];
          lpc_pkg::REG_FILE_LEN:   flen_r       <= cfg_data[OW-1:0];
          default: ;
        endcase
      end
      // fill response or reject completes at accept
      if (cmd.accept && sts.fast) begin
        if (!reject) begin
          pend_r <= 1'b0;
          if (in_got_bytes != pend_len_r) begin
            valid_r[pend_slot_r] <= 1'b0;
            tag_r[pend_slot_r]   <= '0;
            fill_r[pend_slot_r]  <= '0;
            stamp_r[pend_slot_r] <= '0;
            short_cnt_r          <= short_cnt_r + CW'(1);
          end else begin
            valid_r[pend_slot_r] <= 1'b1;
            tag_r[pend_slot_r]   <= pend_base_r;
            fill_r[pend_slot_r]  <= in_got_bytes;
            stamp_r[pend_slot_r] <= stamp_inc;
            stamp_cnt_r          <= stamp_inc;
          end
        end
      end
      // close out a read or prefetch
      if (cmd.finish) begin
        if (hit_r) begin
          stamp_r[hslot_r] <= stamp_inc;
          stamp_cnt_r      <= stamp_inc;
          if (is_read_r) begin
            hit_cnt_r <= hit_cnt_r + CW'(1);
          end
        end else begin
          miss_cnt_r <= miss_cnt_r + CW'(1);
          pend_r     <= 1'b1;
        end
      end
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_read_r <= (in_action == lpc_pkg::ACT_READ);
      off_r     <= in_byte_offset;
      rem_r     <= rem_clamp;
    end
    if (cmd.div_latch) begin
      within_r <= div_rem;
      base_r   <= off_r - {{(OW-WW){1'b0}}, div_rem};
      idx_r    <= '0;
      vict_r   <= '0;
      free_r   <= 1'b0;
      hit_r    <= 1'b0;
      vstamp_r <= '1;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + SW'(1);
      if (sts.hit_now) begin
        hit_r   <= 1'b1;
        hslot_r <= idx_r;
      end else if (!free_r) begin
        if (!valid_r[idx_r]) begin
          vict_r <= idx_r;
          free_r <= 1'b1;
        end else if (stamp_r[idx_r] < vstamp_r) begin
          vict_r   <= idx_r;
          vstamp_r <= stamp_r[idx_r];
        end
      end
    end
    if (cmd.accept && sts.fast) begin
      if (reject) begin
        ost_r   <= lpc_pkg::ST_REJECT;
        oslot_r <= '0;
        obase_r <= '0;
        oflen_r <= '0;
        owin_r  <= '0;
        otake_r <= '0;
      end else begin
        oslot_r <= pend_slot_r;
        obase_r <= pend_base_r;
        oflen_r <= pend_len_r;
        if (in_got_bytes != pend_len_r) begin
          ost_r   <= lpc_pkg::ST_SHORT;
          owin_r  <= '0;
          otake_r <= '0;
        end else begin
          ost_r   <= lpc_pkg::ST_FILLED;
          owin_r  <= pend_read_r ? pend_within_r : '0;
          otake_r <= pend_read_r ? take_from(in_got_bytes, pend_within_r, pend_rem_r) : '0;
        end
      end
    end
    if (cmd.finish) begin
      obase_r <= base_r;
      if (hit_r) begin
        oslot_r <= hslot_r;
        oflen_r <= '0;
        if (is_read_r) begin
          ost_r   <= lpc_pkg::ST_HIT;
          owin_r  <= within_r;
          otake_r <= take_from(fill_r[hslot_r], within_r, rem_r);
        end else begin
          ost_r   <= lpc_pkg::ST_PREHIT;
          owin_r  <= '0;
          otake_r <= '0;
        end
      end else begin
        ost_r         <= lpc_pkg::ST_FETCH;
        oslot_r       <= vict_r;
        oflen_r       <= want;
        owin_r        <= within_r;
        otake_r       <= '0;
        pend_slot_r   <= vict_r;
        pend_base_r   <= base_r;
        pend_len_r    <= want;
        pend_read_r   <= is_read_r;
        pend_within_r <= within_r;
        pend_rem_r    <= rem_r;
      end
    end
  end

  assign out_valid            = ov_r;
  assign out_status           = ost_r;
  assign out_page_slot        = oslot_r;
  assign out_page_base        = obase_r;
  assign out_fetch_length     = oflen_r;
  assign out_within_offset    = owin_r;
  assign out_take_bytes       = otake_r;
  assign out_hit_total        = hit_cnt_r;
  assign out_miss_total       = miss_cnt_r;
  assign out_short_read_total = short_cnt_r;

endmodule

/* hw/rtl/lru_page_cache_controller.sv */
// Fully associative page cache controller with LRU replacement (tags and fill
// counts only). Requests enter on start/in_* and are taken when start is high
// and busy is low. Each request yields one result, shown on out_* for exactly
// one cycle with out_valid high; the receiver must take it then.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 page_bytes, 1 pages_in_use,
// 2 file_length; cfg_ready is always high. Write only while the block is idle.
// Fill responses and rejected requests finish at acceptance, with out_valid
// the cycle after acceptance. Reads and prefetches go through these steps:
// accept, the bit-serial page divider, the one-slot-per-cycle tag and age scan
// over the slots in use until a hit or the last one, then finish. busy is high
// from the divider step through the finish step.
// Reset clears the slot table, counters, pending fetch and sets the registers
// to 512 bytes per page, 16 slots, file length zero.
// The result side cannot stall; the counter outputs always show current totals.
module lru_page_cache_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [lpc_pkg::OFF_W-1:0]   in_byte_offset,
  input  logic [lpc_pkg::LEN_W-1:0]   in_remaining_bytes,
  input  logic [lpc_pkg::LEN_W-1:0]   in_got_bytes,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [lpc_pkg::SLOT_W-1:0]  out_page_slot,
  output logic [lpc_pkg::OFF_W-1:0]   out_page_base,
  output logic [lpc_pkg::LEN_W-1:0]   out_fetch_length,
  output logic [lpc_pkg::WIN_W-1:0]   out_within_offset,
  output logic [lpc_pkg::LEN_W-1:0]   out_take_bytes,
  output logic [lpc_pkg::CNT_W-1:0]   out_hit_total,
  output logic [lpc_pkg::CNT_W-1:0]   out_miss_total,
  output logic [lpc_pkg::CNT_W-1:0]   out_short_read_total,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  lpc_pkg::cmd_t cmd;
  lpc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lpc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_action            (in_action),
    .in_byte_offset       (in_byte_offset),
    .in_remaining_bytes   (in_remaining_bytes),
    .in_got_bytes         (in_got_bytes),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_page_slot        (out_page_slot),
    .out_page_base        (out_page_base),
    .out_fetch_length     (out_fetch_length),
    .out_within_offset    (out_within_offset),
    .out_take_bytes       (out_take_bytes),
    .out_hit_total        (out_hit_total),
    .out_miss_total       (out_miss_total),
    .out_short_read_total (out_short_read_total)
  );

endmodule
